### hw/rtl/crot_pkg.sv
// shared constants, quadrant codes and cordic arctangent table
package crot_pkg;

    localparam int ANGLE_W      = 16;
    localparam int DIM          = 3;
    localparam int CORDIC_FRAC  = 30;
    localparam int CORDIC_W     = 34;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_START = 34'sd652032874;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // arctangent of 2^-i, full turn is 2^32
    function automatic logic [31:0] atan_turns(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            default: v = 32'h00000051;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/crot_front.sv
// front end: quadrant fold and pipelined cordic sine and cosine
module crot_front import crot_pkg::*; #(
    parameter int DATA_WIDTH  = 32,
    parameter int TRIG_STAGES = 16,
    parameter int COEF_W      = 64 - DATA_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ANGLE_W-1:0]                in_angle,
    input  logic [DIM*DIM-1:0][DATA_WIDTH-1:0] in_mat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [COEF_W-1:0]          out_cos,
    output logic signed [COEF_W-1:0]          out_sin,
    output logic [DIM*DIM-1:0][DATA_WIDTH-1:0] out_mat
);
    localparam int F  = 61 - DATA_WIDTH;
    localparam int NS = TRIG_STAGES;

    logic                               vld_reg [0:NS+1];
    logic signed [CORDIC_W-1:0]         x_reg   [0:NS];
    logic signed [CORDIC_W-1:0]         y_reg   [0:NS];
    logic signed [CORDIC_W-1:0]         z_reg   [0:NS];
    quad_t                              q_reg   [0:NS];
    logic [DIM*DIM-1:0][DATA_WIDTH-1:0] mat_reg [0:NS+1];
    logic signed [COEF_W-1:0]           cos_reg, sin_reg;
    logic signed [COEF_W-1:0]           cos_next, sin_next;
    logic signed [CORDIC_W-1:0]         c_raw, s_raw;
    logic                               en;
    logic [1:0]                         quad;
    logic [ANGLE_W-1:0]                 resid;
    logic [ANGLE_W-1:0]                 angle_off;

    assign en        = !vld_reg[NS+1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NS+1];
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_mat   = mat_reg[NS+1];

    assign angle_off = in_angle + ANGLE_W'(8192);
    assign quad      = angle_off[ANGLE_W-1:ANGLE_W-2];
    assign resid     = in_angle - {quad, {(ANGLE_W-2){1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NS + 1; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= NS + 1; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= CORDIC_GAIN_START;
            y_reg[0]   <= '0;
            z_reg[0]   <= CORDIC_W'($signed(resid)) <<< 16;
            q_reg[0]   <= quad_t'(quad);
            mat_reg[0] <= in_mat;
            for (int i = 0; i < NS; i++) begin
                if (!z_reg[i][CORDIC_W-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - CORDIC_W'(atan_turns(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + CORDIC_W'(atan_turns(i));
                end
                q_reg[i+1]   <= q_reg[i];
                mat_reg[i+1] <= mat_reg[i];
            end
            mat_reg[NS+1] <= mat_reg[NS];
            cos_reg       <= cos_next;
            sin_reg       <= sin_next;
        end
    end

    always_comb begin
        unique case (q_reg[NS])
            QUAD_0:  begin c_raw = x_reg[NS];  s_raw = y_reg[NS];  end
            QUAD_1:  begin c_raw = -y_reg[NS]; s_raw = x_reg[NS];  end
            QUAD_2:  begin c_raw = -x_reg[NS]; s_raw = -y_reg[NS]; end
            default: begin c_raw = y_reg[NS];  s_raw = -x_reg[NS]; end
        endcase
    end

    generate
        if (F < CORDIC_FRAC) begin : g_round
            localparam int SH = CORDIC_FRAC - F;
            localparam logic signed [CORDIC_W-1:0] RND = CORDIC_W'(1) <<< (SH - 1);
            logic signed [CORDIC_W-1:0] cr, sr;
            assign cr       = (c_raw + RND) >>> SH;
            assign sr       = (s_raw + RND) >>> SH;
            assign cos_next = COEF_W'(cr);
            assign sin_next = COEF_W'(sr);
        end else begin : g_exact
            assign cos_next = COEF_W'(c_raw) <<< (F - CORDIC_FRAC);
            assign sin_next = COEF_W'(s_raw) <<< (F - CORDIC_FRAC);
        end
    endgenerate

endmodule

### hw/rtl/crot_queue.sv
// two entry queue between front and back end
module crot_queue import crot_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int COEF_W     = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_valid,
    output logic                              wr_ready,
    input  logic signed [COEF_W-1:0]          wr_cos,
    input  logic signed [COEF_W-1:0]          wr_sin,
    input  logic [DIM*DIM-1:0][DATA_WIDTH-1:0] wr_mat,
    output logic                              rd_valid,
    input  logic                              rd_ready,
    output logic signed [COEF_W-1:0]          rd_cos,
    output logic signed [COEF_W-1:0]          rd_sin,
    output logic [DIM*DIM-1:0][DATA_WIDTH-1:0] rd_mat
);
    logic signed [COEF_W-1:0]           cos_mem [0:1];
    logic signed [COEF_W-1:0]           sin_mem [0:1];
    logic [DIM*DIM-1:0][DATA_WIDTH-1:0] mat_mem [0:1];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_cos   = cos_mem[rptr_reg];
    assign rd_sin   = sin_mem[rptr_reg];
    assign rd_mat   = mat_mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= !wptr_reg;
            if (pop) rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            cos_mem[wptr_reg] <= wr_cos;
            sin_mem[wptr_reg] <= wr_sin;
            mat_mem[wptr_reg] <= wr_mat;
        end
    end

endmodule

### hw/rtl/crot_back.sv
// back end: two rotation passes, rounding and saturation
module crot_back import crot_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int COEF_W     = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COEF_W-1:0]          in_cos,
    input  logic signed [COEF_W-1:0]          in_sin,
    input  logic [DIM*DIM-1:0][DATA_WIDTH-1:0] in_mat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [DIM*DIM-1:0][DATA_WIDTH-1:0] out_res
);
    localparam int DW  = DATA_WIDTH;
    localparam int F   = 61 - DATA_WIDTH;
    localparam int PW  = DW + COEF_W + 1;
    localparam int SW  = PW + 1;
    localparam int TW  = DW + 2;
    localparam int QW  = TW + COEF_W + 1;
    localparam int QSW = QW + 1;
    localparam logic signed [SW-1:0]  RND1 = SW'(1) <<< (F - 1);
    localparam logic signed [QSW-1:0] RND2 = QSW'(1) <<< (F - 1);
    localparam logic signed [QSW-1:0] SMAX = {{(QSW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [QSW-1:0] SMIN = ~SMAX;

    logic vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg;
    logic en;

    logic signed [PW-1:0]     pa_reg [0:DIM-1];
    logic signed [PW-1:0]     pb_reg [0:DIM-1];
    logic signed [PW-1:0]     pc_reg [0:DIM-1];
    logic signed [PW-1:0]     pd_reg [0:DIM-1];
    logic signed [DW-1:0]     m2_reg [0:DIM-1];
    logic signed [COEF_W-1:0] ca_reg, sa_reg, cb_reg, sb_reg;
    logic signed [TW-1:0]     t_reg  [0:DIM*DIM-1];
    logic signed [QW-1:0]     qa_reg [0:DIM-1];
    logic signed [QW-1:0]     qb_reg [0:DIM-1];
    logic signed [QW-1:0]     qc_reg [0:DIM-1];
    logic signed [QW-1:0]     qd_reg [0:DIM-1];
    logic signed [TW-1:0]     t2_reg [0:DIM-1];
    logic [DIM*DIM-1:0][DW-1:0] res_reg;
    logic [DIM*DIM-1:0][DW-1:0] res_next;
    logic signed [TW-1:0]     t_next [0:DIM*DIM-1];

    function automatic logic [DW-1:0] sat(input logic signed [QSW-1:0] v);
        logic [DW-1:0] r;
        if (v > SMAX)      r = SMAX[DW-1:0];
        else if (v < SMIN) r = SMIN[DW-1:0];
        else               r = v[DW-1:0];
        return r;
    endfunction

    assign en        = !vld_d_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_d_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end else if (en) begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
        end
    end

    // row pass sums
    always_comb begin
        logic signed [SW-1:0] s0, s1;
        for (int j = 0; j < DIM; j++) begin
            s0 = SW'(pa_reg[j]) + SW'(pb_reg[j]) + RND1;
            s1 = SW'(pc_reg[j]) - SW'(pd_reg[j]) + RND1;
            t_next[j]       = TW'(s0 >>> F);
            t_next[DIM + j] = TW'(s1 >>> F);
            t_next[2*DIM + j] = TW'(m2_reg[j]);
        end
    end

    // column pass sums
    always_comb begin
        logic signed [QSW-1:0] b0, b1;
        for (int i = 0; i < DIM; i++) begin
            b0 = (QSW'(qa_reg[i]) + QSW'(qb_reg[i]) + RND2) >>> F;
            b1 = (QSW'(qc_reg[i]) - QSW'(qd_reg[i]) + RND2) >>> F;
            res_next[i*DIM]     = sat(b0);
            res_next[i*DIM + 1] = sat(b1);
            res_next[i*DIM + 2] = sat(QSW'(t2_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < DIM; j++) begin
                pa_reg[j] <= PW'(in_cos) * PW'($signed(in_mat[j]));
                pb_reg[j] <= PW'(in_sin) * PW'($signed(in_mat[DIM + j]));
                pc_reg[j] <= PW'(in_cos) * PW'($signed(in_mat[DIM + j]));
                pd_reg[j] <= PW'(in_sin) * PW'($signed(in_mat[j]));
                m2_reg[j] <= $signed(in_mat[2*DIM + j]);
            end
            ca_reg <= in_cos;
            sa_reg <= in_sin;
            for (int k = 0; k < DIM*DIM; k++) t_reg[k] <= t_next[k];
            cb_reg <= ca_reg;
            sb_reg <= sa_reg;
            for (int i = 0; i < DIM; i++) begin
                qa_reg[i] <= QW'(t_reg[i*DIM]) * QW'(cb_reg);
                qb_reg[i] <= QW'(t_reg[i*DIM + 1]) * QW'(sb_reg);
                qc_reg[i] <= QW'(t_reg[i*DIM + 1]) * QW'(cb_reg);
                qd_reg[i] <= QW'(t_reg[i*DIM]) * QW'(sb_reg);
                t2_reg[i] <= t_reg[i*DIM + 2];
            end
            res_reg <= res_next;
        end
    end

endmodule

### hw/rtl/covariance_rotation_3x3_unit.sv
// top level of the 3x3 covariance rotation unit
//
// rotates a 3x3 covariance by a heading angle: result = R^T * C * R
// input channel s_*: one binary angle (65536 per turn) and nine q16.16 entries
// output channel m_*: nine rotated entries, rounded and saturated
// both channels use valid/ready; a request moves on valid && ready
// throughput: one request per cycle when the receiver keeps m_ready high
// a request passes the cordic stage pipeline in the front end, the queue and then
// the four stage matrix pipeline in the back
// the front end and the back end stall on their own, joined by a two entry
// queue; when m_ready is low the back end holds its result and then the
// queue and the front end fill, after which s_ready drops
// reset (aresetn low, synchronous) empties every stage and the queue
// and no result is shown until new requests arrive
module covariance_rotation_3x3_unit import crot_pkg::*; #(
    parameter int DATA_WIDTH  = 32,
    parameter int TRIG_STAGES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ANGLE_W-1:0]           s_turn_angle,
    input  logic signed [DATA_WIDTH-1:0] s_cov_r0c0,
    input  logic signed [DATA_WIDTH-1:0] s_cov_r0c1,
    input  logic signed [DATA_WIDTH-1:0] s_cov_r0c2,
    input  logic signed [DATA_WIDTH-1:0] s_cov_r1c0,
    input  logic signed [DATA_WIDTH-1:0] s_cov_r1c1,
    input  logic signed [DATA_WIDTH-1:0] s_cov_r1c2,
    input  logic signed [DATA_WIDTH-1:0] s_cov_r2c0,
    input  logic signed [DATA_WIDTH-1:0] s_cov_r2c1,
    input  logic signed [DATA_WIDTH-1:0] s_cov_r2c2,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_res_r0c0,
    output logic signed [DATA_WIDTH-1:0] m_res_r0c1,
    output logic signed [DATA_WIDTH-1:0] m_res_r0c2,
    output logic signed [DATA_WIDTH-1:0] m_res_r1c0,
    output logic signed [DATA_WIDTH-1:0] m_res_r1c1,
    output logic signed [DATA_WIDTH-1:0] m_res_r1c2,
    output logic signed [DATA_WIDTH-1:0] m_res_r2c0,
    output logic signed [DATA_WIDTH-1:0] m_res_r2c1,
    output logic signed [DATA_WIDTH-1:0] m_res_r2c2
);
    localparam int COEF_W = 64 - DATA_WIDTH;

    logic [DIM*DIM-1:0][DATA_WIDTH-1:0] in_mat, f_mat, q_mat, res;
    logic signed [COEF_W-1:0] f_cos, f_sin, q_cos, q_sin;
    logic f_valid, f_ready, q_valid, q_ready;

    assign in_mat = {s_cov_r2c2, s_cov_r2c1, s_cov_r2c0,
                     s_cov_r1c2, s_cov_r1c1, s_cov_r1c0,
                     s_cov_r0c2, s_cov_r0c1, s_cov_r0c0};

    crot_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .TRIG_STAGES(TRIG_STAGES),
        .COEF_W     (COEF_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_angle (s_turn_angle),
        .in_mat   (in_mat),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_cos  (f_cos),
        .out_sin  (f_sin),
        .out_mat  (f_mat)
    );

    crot_queue #(
        .DATA_WIDTH(DATA_WIDTH),
        .COEF_W    (COEF_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(f_valid),
        .wr_ready(f_ready),
        .wr_cos  (f_cos),
        .wr_sin  (f_sin),
        .wr_mat  (f_mat),
        .rd_valid(q_valid),
        .rd_ready(q_ready),
        .rd_cos  (q_cos),
        .rd_sin  (q_sin),
        .rd_mat  (q_mat)
    );

    crot_back #(
        .DATA_WIDTH(DATA_WIDTH),
        .COEF_W    (COEF_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_cos   (q_cos),
        .in_sin   (q_sin),
        .in_mat   (q_mat),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_res  (res)
    );

    assign m_res_r0c0 = res[0];
    assign m_res_r0c1 = res[1];
    assign m_res_r0c2 = res[2];
    assign m_res_r1c0 = res[3];
    assign m_res_r1c1 = res[4];
    assign m_res_r1c2 = res[5];
    assign m_res_r2c0 = res[6];
    assign m_res_r2c1 = res[7];
    assign m_res_r2c2 = res[8];

endmodule

### hw/rtl/crot_checker.sv
// port level checks for the covariance rotation unit, with bind
module crot_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [DATA_WIDTH-1:0] m_res_r0c0,
    input logic [DATA_WIDTH-1:0] m_res_r1c1
);
    logic [7:0] pend_reg;
    logic [7:0] pend_next;

    always_comb begin
        pend_next = pend_reg;
        if (s_valid && s_ready) pend_next = pend_next + 8'd1;
        if (m_valid && m_ready) pend_next = pend_next - 8'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // no result without an outstanding request
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 8'd0)
        else $error("result without pending request");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_res_r0c0) && $stable(m_res_r1c1))
        else $error("result changed while stalled");

endmodule

bind covariance_rotation_3x3_unit crot_checker #(
    .DATA_WIDTH(DATA_WIDTH)
) u_crot_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_res_r0c0(m_res_r0c0),
    .m_res_r1c1(m_res_r1c1)
);

### tb/tb_covariance_rotation_3x3_unit.sv
// self-checking testbench for the 3x3 covariance rotation unit
module tb_covariance_rotation_3x3_unit;
    import crot_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 32;
    localparam int STAGES = 16;
    localparam int COEF_F = 61 - DW;
    localparam int N_RAND = 1930;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        logic signed [DW-1:0] m [9];
    } cov_req_t;

    typedef struct {
        logic signed [DW-1:0] m [9];
    } rot_cov_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ANGLE_W-1:0] s_turn_angle = '0;
    logic signed [DW-1:0] s_cov [9];
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DW-1:0] m_res [9];

    cov_req_t pending_reqs [$];
    rot_cov_t expected_covs [$];
    int errors = 0;
    longint cycles = 0;
    bit feed_done = 1'b0;
    bit calm = 1'b0;
    int src_gap = 0;
    int sink_hold = 0;
    int long_hold = 0;

    initial for (int k = 0; k < 9; k++) s_cov[k] = '0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    covariance_rotation_3x3_unit #(.DATA_WIDTH(DW), .TRIG_STAGES(STAGES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_turn_angle(s_turn_angle),
        .s_cov_r0c0(s_cov[0]), .s_cov_r0c1(s_cov[1]), .s_cov_r0c2(s_cov[2]),
        .s_cov_r1c0(s_cov[3]), .s_cov_r1c1(s_cov[4]), .s_cov_r1c2(s_cov[5]),
        .s_cov_r2c0(s_cov[6]), .s_cov_r2c1(s_cov[7]), .s_cov_r2c2(s_cov[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_res_r0c0(m_res[0]), .m_res_r0c1(m_res[1]), .m_res_r0c2(m_res[2]),
        .m_res_r1c0(m_res[3]), .m_res_r1c1(m_res[4]), .m_res_r1c2(m_res[5]),
        .m_res_r2c0(m_res[6]), .m_res_r2c1(m_res[7]), .m_res_r2c2(m_res[8])
    );

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [DW-1:0] clamp_dw(longint v);
        longint hi, lo;
        hi = (longint'(1) << (DW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[DW-1:0];
    endfunction

    function automatic void heading_trig(input logic [ANGLE_W-1:0] a,
                                         output longint cs, output longint sn);
        logic [15:0] qsum, res16;
        quad_t quad;
        longint x, y, z, dx, dy, c, s;
        qsum = a + 16'd8192;
        quad = quad_t'(qsum[15:14]);
        res16 = a - {quad, 14'd0};
        x = CORDIC_GAIN_START;
        y = 0;
        z = longint'($signed(res16)) * 65536;
        for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turns(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turns(i));
            end
        end
        case (quad)
            QUAD_0: begin c = x; s = y; end
            QUAD_1: begin c = -y; s = x; end
            QUAD_2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        if (COEF_F < CORDIC_FRAC) begin
            cs = round_half_up(c, CORDIC_FRAC - COEF_F);
            sn = round_half_up(s, CORDIC_FRAC - COEF_F);
        end else begin
            cs = c <<< (COEF_F - CORDIC_FRAC);
            sn = s <<< (COEF_F - CORDIC_FRAC);
        end
    endfunction

    function automatic rot_cov_t rotate_cov(cov_req_t r);
        rot_cov_t o;
        longint c, s;
        longint m [3][3];
        longint t [3][3];
        heading_trig(r.angle, c, s);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) m[i][j] = longint'(r.m[i*3+j]);
        for (int j = 0; j < 3; j++) begin
            t[0][j] = round_half_up(c * m[0][j] + s * m[1][j], COEF_F);
            t[1][j] = round_half_up(c * m[1][j] - s * m[0][j], COEF_F);
            t[2][j] = m[2][j];
        end
        for (int i = 0; i < 3; i++) begin
            o.m[i*3]   = clamp_dw(round_half_up(t[i][0] * c + t[i][1] * s, COEF_F));
            o.m[i*3+1] = clamp_dw(round_half_up(t[i][1] * c - t[i][0] * s, COEF_F));
            o.m[i*3+2] = clamp_dw(t[i][2]);
        end
        return o;
    endfunction

    function automatic logic signed [DW-1:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(DW-1){1'b1}}};
            1: return {1'b1, {(DW-1){1'b0}}};
            2: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            3: return $signed(DW'($urandom_range(0, 32'h0003ffff)));
            default: return DW'($urandom);
        endcase
    endfunction

    function automatic cov_req_t rand_req();
        cov_req_t r;
        r.angle = (($urandom_range(0, 3) == 0) ? 16'({$urandom_range(0, 7), 13'd0})
                   + 16'($urandom_range(0, 2)) - 16'd1 : 16'($urandom));
        for (int k = 0; k < 9; k++) r.m[k] = rand_entry();
        return r;
    endfunction

    task automatic push_req(logic [ANGLE_W-1:0] a, logic signed [DW-1:0] v);
        cov_req_t r;
        r.angle = a;
        for (int k = 0; k < 9; k++) r.m[k] = v + DW'(k * 65536);
        pending_reqs.push_back(r);
    endtask

    initial begin
        cov_req_t r;
        logic [ANGLE_W-1:0] angs [8];
        angs = '{16'd0, 16'd8192, 16'd16384, 16'd32768,
                 16'd49152, 16'd65535, 16'd24575, 16'd57344};
        for (int k = 0; k < 8; k++) push_req(angs[k], 32'sh00010000);
        for (int k = 0; k < 4; k++) begin
            r.angle = angs[k + 1];
            for (int j = 0; j < 9; j++)
                r.m[j] = (k[0] ^ j[0]) ? {1'b0, {(DW-1){1'b1}}} : {1'b1, {(DW-1){1'b0}}};
            pending_reqs.push_back(r);
        end
        push_req(16'd0, '0);
        push_req(16'd12345, -32'sd1);
        push_req(16'hffff, 32'sh7fff0000);
        for (int k = 0; k < N_RAND; k++) pending_reqs.push_back(rand_req());
        feed_done = 1'b1;
    end

    // driver
    always @(posedge aclk) begin
        cov_req_t r;
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    expected_covs.push_back(rotate_cov(r));
                    s_valid <= 1'b1;
                    s_turn_angle <= r.angle;
                    for (int k = 0; k < 9; k++) s_cov[k] <= r.m[k];
                    if (!calm && $urandom_range(0, 29) == 0)
                        src_gap <= $urandom_range(1, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (aresetn) begin
            if (long_hold > 0) begin
                long_hold <= long_hold - 1;
                m_ready <= (long_hold == 1);
            end else if (cycles == 1000) begin
                long_hold <= 300;
                m_ready <= 1'b0;
            end else if (sink_hold > 0) begin
                sink_hold <= sink_hold - 1;
                m_ready <= (sink_hold == 1);
            end else if (!calm && $urandom_range(0, 24) == 0) begin
                sink_hold <= $urandom_range(1, 19);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        rot_cov_t e;
        cycles <= cycles + 1;
        calm <= pending_reqs.size() < 200;
        if (aresetn && m_valid && m_ready) begin
            if (expected_covs.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                errors++;
            end else begin
                e = expected_covs.pop_front();
                for (int k = 0; k < 9; k++)
                    if (m_res[k] !== e.m[k]) begin
                        $display("%0t: entry r%0dc%0d expected %0d actual %0d",
                                 $time, k / 3, k % 3, e.m[k], m_res[k]);
                        errors++;
                    end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(feed_done && pending_reqs.size() == 0 && expected_covs.size() == 0
                 && !s_valid) && cycles < CYCLE_LIMIT)
            @(posedge aclk);
        if (cycles >= CYCLE_LIMIT) begin
            $display("covariance_rotation_3x3_unit: mismatch");
            $finish;
        end else begin
            repeat (STAGES + 20) @(posedge aclk);
            if (errors == 0)
                $display("covariance_rotation_3x3_unit: match");
            else
                $display("covariance_rotation_3x3_unit: mismatch");
            $finish;
        end
    end
endmodule

### filelist.f
hw/rtl/crot_pkg.sv
hw/rtl/crot_front.sv
hw/rtl/crot_queue.sv
hw/rtl/crot_back.sv
hw/rtl/covariance_rotation_3x3_unit.sv
hw/rtl/crot_checker.sv
tb/tb_covariance_rotation_3x3_unit.sv
